// ===== design/rdws_pkg.sv =====
// ----------------------------------------------------------------------------
// rdws_pkg
// Shared widths, defaults and command codes for the work-stealing ring deque.
// ----------------------------------------------------------------------------
package rdws_pkg;

    localparam int WORD_W        = 64;
    localparam int CMD_W         = 2;
    localparam int REQ_W         = 7;
    localparam int OCC_W         = 7;
    localparam int CFG_W         = 7;
    localparam int DEPTH_DEFAULT = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_TAIL = 2'd0,
        CMD_POP_HEAD  = 2'd1,
        CMD_POP_TAIL  = 2'd2,
        CMD_POP_MANY  = 2'd3
    } cmd_t;

endpackage

// ===== design/rdws_ram.sv =====
// ----------------------------------------------------------------------------
// rdws_ram
// Slot storage: one write port, one read port, registered read data that
// holds while no read is issued.
// ----------------------------------------------------------------------------
module rdws_ram #(
    parameter int DEPTH = rdws_pkg::DEPTH_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [rdws_pkg::WORD_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic [rdws_pkg::WORD_W-1:0] rd_data
);

    logic [rdws_pkg::WORD_W-1:0] mem [DEPTH];
    logic [rdws_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ring_deque_work_steal.sv =====
// ----------------------------------------------------------------------------
// ring_deque_work_steal
// Circular deque of 64-bit words: push at tail, pop at head or tail, and
// batch pop from head, one result word per popped entry.
// Push: result registered in the cycle after accept, one push per cycle while the output is not stalled.
// Single pop: the slot RAM read is issued at accept and its registered data is output from S_READ.
// Batch pop of n words: one word per cycle from the RAM port while the output is not stalled.
// Reset (aresetn low, synchronous): deque empty, capacity DEPTH, no result.
// ----------------------------------------------------------------------------
module ring_deque_work_steal #(
    parameter int DEPTH = rdws_pkg::DEPTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rdws_pkg::CFG_W-1:0]   cfg_data,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [rdws_pkg::CMD_W-1:0]   s_cmd,
    input  logic [rdws_pkg::WORD_W-1:0]  s_data,
    input  logic [rdws_pkg::REQ_W-1:0]   s_request_count,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_ok,
    output logic [rdws_pkg::WORD_W-1:0]  m_word,
    output logic [rdws_pkg::OCC_W-1:0]   m_occupancy,
    output logic                         m_last
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [0:0] {
        S_IDLE,
        S_READ
    } state_t;

    state_t                      state_reg;
    logic [IDX_W-1:0]            head_reg;
    logic [IDX_W-1:0]            tail_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            cap_reg;
    logic [CNT_W-1:0]            rem_reg;
    logic [CNT_W-1:0]            occ_pend_reg;

    logic                        out_valid_reg;
    logic                        out_ok_reg;
    logic [rdws_pkg::WORD_W-1:0] out_word_reg;
    logic [CNT_W-1:0]            out_occ_reg;
    logic                        out_last_reg;

    rdws_pkg::cmd_t              cmd;
    logic                        out_free;
    logic                        accept;
    logic                        is_full;
    logic                        is_empty;
    logic [CNT_W-1:0]            head_plus;
    logic [CNT_W-1:0]            tail_plus;
    logic [IDX_W-1:0]            head_inc;
    logic [IDX_W-1:0]            tail_inc;
    logic [IDX_W-1:0]            tail_dec;
    logic [CNT_W-1:0]            req_n;
    logic [CNT_W-1:0]            cap_eff;
    logic                        issue_head;
    logic                        issue_tail;
    logic                        wr_en;
    logic                        rd_en;
    logic [IDX_W-1:0]            rd_addr;
    logic [rdws_pkg::WORD_W-1:0] rd_data;

    assign cmd       = rdws_pkg::cmd_t'(s_cmd);
    assign out_free  = !out_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign is_full   = (count_reg >= cap_reg);
    assign is_empty  = (count_reg == '0);

    assign head_plus = CNT_W'(head_reg) + CNT_W'(1);
    assign tail_plus = CNT_W'(tail_reg) + CNT_W'(1);
    assign head_inc  = (head_plus >= cap_reg) ? '0 : IDX_W'(head_plus);
    assign tail_inc  = (tail_plus >= cap_reg) ? '0 : IDX_W'(tail_plus);
    assign tail_dec  = (tail_reg == '0) ? IDX_W'(cap_reg - CNT_W'(1))
                                        : tail_reg - IDX_W'(1);

    assign req_n = (s_request_count < rdws_pkg::REQ_W'(count_reg))
                 ? CNT_W'(s_request_count) : count_reg;

    always_comb begin
        if (cfg_data == '0) begin
            cap_eff = CNT_W'(1);
        end else if (cfg_data > rdws_pkg::CFG_W'(DEPTH)) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = CNT_W'(cfg_data);
        end
    end

    assign wr_en      = accept && (cmd == rdws_pkg::CMD_PUSH_TAIL) && !is_full;
    assign issue_tail = accept && (cmd == rdws_pkg::CMD_POP_TAIL) && !is_empty;
    assign issue_head = (accept && (cmd == rdws_pkg::CMD_POP_HEAD) && !is_empty)
                     || (accept && (cmd == rdws_pkg::CMD_POP_MANY) && (req_n != '0))
                     || ((state_reg == S_READ) && out_free && (rem_reg != '0));
    assign rd_en      = issue_head || issue_tail;
    assign rd_addr    = issue_tail ? tail_dec : head_reg;

    rdws_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (s_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= CNT_W'(DEPTH);
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (issue_head) begin
                head_reg     <= head_inc;
                count_reg    <= count_reg - CNT_W'(1);
                occ_pend_reg <= count_reg - CNT_W'(1);
            end
            if (issue_tail) begin
                tail_reg     <= tail_dec;
                count_reg    <= count_reg - CNT_W'(1);
                occ_pend_reg <= count_reg - CNT_W'(1);
            end

            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        case (cmd)
                            rdws_pkg::CMD_PUSH_TAIL: begin
                                out_valid_reg <= 1'b1;
                                out_word_reg  <= '0;
                                out_last_reg  <= 1'b1;
                                if (is_full) begin
                                    out_ok_reg  <= 1'b0;
                                    out_occ_reg <= count_reg;
                                end else begin
                                    out_ok_reg  <= 1'b1;
                                    out_occ_reg <= count_reg + CNT_W'(1);
                                    tail_reg    <= tail_inc;
                                    count_reg   <= count_reg + CNT_W'(1);
                                end
                            end
                            rdws_pkg::CMD_POP_HEAD, rdws_pkg::CMD_POP_TAIL: begin
                                if (is_empty) begin
                                    out_valid_reg <= 1'b1;
                                    out_ok_reg    <= 1'b0;
                                    out_word_reg  <= '0;
                                    out_occ_reg   <= count_reg;
                                    out_last_reg  <= 1'b1;
                                end else begin
                                    state_reg <= S_READ;
                                    rem_reg   <= '0;
                                end
                            end
                            default: begin
                                if (req_n == '0) begin
                                    out_valid_reg <= 1'b1;
                                    out_ok_reg    <= 1'b0;
                                    out_word_reg  <= '0;
                                    out_occ_reg   <= count_reg;
                                    out_last_reg  <= 1'b1;
                                end else begin
                                    state_reg <= S_READ;
                                    rem_reg   <= req_n - CNT_W'(1);
                                end
                            end
                        endcase
                    end
                end
                S_READ: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_ok_reg    <= 1'b1;
                        out_word_reg  <= rd_data;
                        out_occ_reg   <= occ_pend_reg;
                        out_last_reg  <= (rem_reg == '0);
                        if (rem_reg == '0) begin
                            state_reg <= S_IDLE;
                        end else begin
                            rem_reg <= rem_reg - CNT_W'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase

            // drop stored words on a capacity write
            if (cfg_valid) begin
                cap_reg   <= cap_eff;
                head_reg  <= '0;
                tail_reg  <= '0;
                count_reg <= '0;
            end
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_ok        = out_ok_reg;
    assign m_word      = out_word_reg;
    assign m_occupancy = rdws_pkg::OCC_W'(out_occ_reg);
    assign m_last      = out_last_reg;

`ifndef ASSERT_OFF
    a_count_in_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cap_reg)
        else $error("stored count exceeds capacity");

    a_index_in_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (CNT_W'(head_reg) < cap_reg) && (CNT_W'(tail_reg) < cap_reg))
        else $error("head or tail index beyond wrap point");

    a_empty_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty deque with head and tail apart");

    a_batch_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_last_reg) |-> (state_reg == S_READ))
        else $error("non-final word while no batch pop is active");

    a_one_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && rd_en))
        else $error("slot write and read in the same cycle");
`endif

endmodule
